FILE: hw/rtl/vt4_pkg.sv
// ----------------------------------------------------------------------------
// vt4_pkg
// Shared widths, types and constants for the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

    localparam int DATA_WIDTH = 32;   // saturation bound of the results
    localparam int FRAC_BITS  = 16;   // fraction bits of the fixed-point format

    localparam int ELEM_W = 32;             // operand and result field width
    localparam int PROD_W = 2 * ELEM_W;     // one exact product
    localparam int PAIR_W = PROD_W + 1;     // sum of two products
    localparam int SUM_W  = PROD_W + 2;     // sum of four products
    localparam int DIM    = 4;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_XFORM = 1'b1;

    localparam logic signed [ELEM_W-1:0] ONE_FX = ELEM_W'(64'sd1 <<< FRAC_BITS);

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((66'sd1 <<< (DATA_WIDTH - 1)) - 66'sd1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(66'sd1);

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef t_elem t_vec      [DIM];
    typedef t_prod t_prod_mat [DIM][DIM];   // [row][col]
    typedef t_sum  t_sum_vec  [DIM];

endpackage

FILE: hw/rtl/vt4_mult.sv
// ----------------------------------------------------------------------------
// vt4_mult
// Matrix store and first pipeline stage: sixteen registered products.
// ----------------------------------------------------------------------------
module vt4_mult
    import vt4_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_kind,
    input  logic [1:0]      i_col,
    input  logic [1:0]      i_row,
    input  t_elem           i_elem_value,
    input  t_vec            i_vec,
    output logic            o_valid,
    input  logic            i_ready,
    output t_prod_mat       o_prod
);

    t_elem     r_mat [DIM][DIM];   // [col][row]
    t_prod_mat r_prod;
    logic      r_valid;
    logic      accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // matrix store, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < DIM; c++) begin
                for (int r = 0; r < DIM; r++) begin
                    r_mat[c][r] <= (c == r) ? ONE_FX : '0;
                end
            end
        end else if (accept && i_kind == KIND_LOAD) begin
            r_mat[i_col][i_row] <= i_elem_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && i_kind == KIND_XFORM;
        end
    end

    // one 32x32 multiplier per matrix entry
    always_ff @(posedge i_clk) begin
        if (accept && i_kind == KIND_XFORM) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_prod[r][c] <= PROD_W'(r_mat[c][r]) * PROD_W'(i_vec[c]);
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

FILE: hw/rtl/vt4_adder.sv
// ----------------------------------------------------------------------------
// vt4_adder
// Two-stage adder tree: product pairs, then the full row sums.
// ----------------------------------------------------------------------------
module vt4_adder
    import vt4_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_prod_mat i_prod,
    output logic      o_valid,
    input  logic      i_ready,
    output t_sum_vec  o_sum
);

    t_pair    r_pair [DIM][2];
    t_sum_vec r_sum;
    logic     r_va;
    logic     r_vb;
    logic     rdy_b;

    assign rdy_b   = !r_vb || i_ready;
    assign o_ready = !r_va || rdy_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (o_ready) r_va <= i_valid;
            if (rdy_b)   r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int r = 0; r < DIM; r++) begin
                r_pair[r][0] <= PAIR_W'(i_prod[r][0]) + PAIR_W'(i_prod[r][1]);
                r_pair[r][1] <= PAIR_W'(i_prod[r][2]) + PAIR_W'(i_prod[r][3]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_va) begin
            for (int r = 0; r < DIM; r++) begin
                r_sum[r] <= SUM_W'(r_pair[r][0]) + SUM_W'(r_pair[r][1]);
            end
        end
    end

    assign o_valid = r_vb;
    assign o_sum   = r_sum;

endmodule

FILE: hw/rtl/vt4_sat.sv
// ----------------------------------------------------------------------------
// vt4_sat
// Output stage: drop fraction bits, saturate, register the result.
// ----------------------------------------------------------------------------
module vt4_sat
    import vt4_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_sum_vec i_sum,
    output logic     o_valid,
    input  logic     i_ready,
    output t_vec     o_res,
    output logic     o_saturated
);

    t_vec  r_res;
    logic  r_sat;
    logic  r_valid;
    t_vec  n_res;
    logic  n_sat;
    t_sum  q;
    logic  hi;
    logic  lo;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_sat = 1'b0;
        q     = '0;
        hi    = 1'b0;
        lo    = 1'b0;
        for (int r = 0; r < DIM; r++) begin
            q  = i_sum[r] >>> FRAC_BITS;
            hi = q > SAT_MAX;
            lo = q < SAT_MIN;
            if (hi) begin
                n_res[r] = SAT_MAX[ELEM_W-1:0];
            end else if (lo) begin
                n_res[r] = SAT_MIN[ELEM_W-1:0];
            end else begin
                n_res[r] = q[ELEM_W-1:0];
            end
            n_sat = n_sat | hi | lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_res       = r_res;
    assign o_saturated = r_sat;

endmodule

FILE: hw/rtl/vertex_transform_4x4.sv
// A transform result is registered in the product, pair-sum, row-sum and output stages in turn.
// Throughput: one item per cycle without a stall; the four stages each hold one transform.
// Load items write the matrix at their input transfer and make no result;
// a following transform already sees the new element.
// Reset (synchronous, active low): matrix becomes identity, pipeline empties.
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Homogeneous 4x4 matrix times vector in signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
module vertex_transform_4x4
    import vt4_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input channel
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_kind,
    input  logic [1:0]   i_col,
    input  logic [1:0]   i_row,
    input  logic signed [ELEM_W-1:0] i_elem_value,
    input  logic signed [ELEM_W-1:0] i_vx,
    input  logic signed [ELEM_W-1:0] i_vy,
    input  logic signed [ELEM_W-1:0] i_vz,
    input  logic signed [ELEM_W-1:0] i_vw,
    // result channel
    output logic         o_valid,
    input  logic         i_ready,
    output logic signed [ELEM_W-1:0] o_rx,
    output logic signed [ELEM_W-1:0] o_ry,
    output logic signed [ELEM_W-1:0] o_rz,
    output logic signed [ELEM_W-1:0] o_rw,
    output logic         o_saturated
);

    // Stage 1: products; stages 2-3: adder tree; stage 4: shift/saturate.
    // Every stage has its own valid and moves when the next one has room,
    // so a stall at the output holds each item in place.

    t_vec      vec;
    t_vec      res;
    t_prod_mat prod;
    t_sum_vec  sum;
    logic      prod_valid;
    logic      prod_ready;
    logic      sum_valid;
    logic      sum_ready;

    assign vec[0] = i_vx;
    assign vec[1] = i_vy;
    assign vec[2] = i_vz;
    assign vec[3] = i_vw;

    vt4_mult u_mult (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_elem_value (i_elem_value),
        .i_vec        (vec),
        .o_valid      (prod_valid),
        .i_ready      (prod_ready),
        .o_prod       (prod)
    );

    vt4_adder u_adder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_prod  (prod),
        .o_valid (sum_valid),
        .i_ready (sum_ready),
        .o_sum   (sum)
    );

    // output register parts the pipeline from the downstream consumer
    vt4_sat u_sat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (sum_valid),
        .o_ready     (sum_ready),
        .i_sum       (sum),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (res),
        .o_saturated (o_saturated)
    );

    assign o_rx = res[0];
    assign o_ry = res[1];
    assign o_rz = res[2];
    assign o_rw = res[3];

endmodule
